// ===== rtl/iaf_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer formatter package
// Shared sizes, request type, character codes and the digit encoder.
// ----------------------------------------------------------------------------
package iaf_pkg;

  localparam int BUFFER_SIZE = 16;
  localparam int CAPACITY    = BUFFER_SIZE - 1;
  localparam int CNT_W       = $clog2(BUFFER_SIZE);
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int DATA_W      = 32;
  localparam int HEX_DIGITS  = DATA_W / 4;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int RECIP_SHIFT = 35;

  localparam logic [DATA_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam logic [DATA_W-1:0] SIGN_BIT  = 32'h8000_0000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] LOWER_ADJ = 8'd39;
  localparam logic [7:0] UPPER_ADJ = 8'd7;

  typedef struct packed {
    logic [DATA_W-1:0] mag;
    logic              neg;
    logic              hex;
    logic              lower;
    logic              zpad;
    logic [CNT_W-1:0]  width;
  } iaf_req_t;

  function automatic logic [7:0] iaf_digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] ch;
    ch = {4'b0000, d} + CH_ZERO;
    if (ch > CH_NINE) begin
      ch = ch + (lower ? LOWER_ADJ : UPPER_ADJ);
    end
    return ch;
  endfunction

endpackage

// ===== rtl/iaf_front.sv =====
// ----------------------------------------------------------------------------
// Integer formatter front end
// Accepts requests, takes the magnitude of negative signed decimal values and
// saturates the field width before the request is queued.
// ----------------------------------------------------------------------------
module iaf_front import iaf_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_hex_radix,
  input  logic              in_lower_case,
  input  logic              in_signed_mode,
  input  logic              in_zero_pad,
  input  logic [3:0]        in_field_width,
  input  logic              q_full,
  output logic              q_push,
  output iaf_req_t          q_req
);

  logic             neg;
  logic [CNT_W-1:0] width_ext;

  assign neg       = !in_hex_radix && in_signed_mode && ((in_value & SIGN_BIT) != '0);
  assign width_ext = CNT_W'(in_field_width);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_req.mag   = neg ? (DATA_W'(0) - in_value) : in_value;
    q_req.neg   = neg;
    q_req.hex   = in_hex_radix;
    q_req.lower = in_lower_case;
    q_req.zpad  = in_zero_pad;
    q_req.width = (width_ext > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : width_ext;
  end

endmodule

// ===== rtl/iaf_queue.sv =====
// ----------------------------------------------------------------------------
// Integer formatter request queue
// A short register queue that decouples the front end from the converter.
// ----------------------------------------------------------------------------
module iaf_queue import iaf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  iaf_req_t push_req,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output iaf_req_t head_req
);

  iaf_req_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_req   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_r != '0)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (push && !pop) |=> count_r == $past(count_r) + QCNT_W'(1))
    else $error("queue count did not follow a push");

endmodule

// ===== rtl/iaf_back.sv =====
// ----------------------------------------------------------------------------
// Integer formatter converter
// Extracts one digit per cycle, least significant first, with a reciprocal
// multiply for base ten, then sends pad, sign and digits most significant first.
// ----------------------------------------------------------------------------
module iaf_back import iaf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  iaf_req_t   head_req,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_last_char
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [DATA_W-1:0] val_r;
  logic [PROD_W-1:0] prod_r;
  logic [CNT_W-1:0]  ndig_r, ndig_nxt;
  logic [3:0]        dig_r [CAPACITY];
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              hex_r, lower_r, neg_r, zpad_r, sign_r;
  logic [CNT_W-1:0]  width_r;
  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              out_last_r;

  logic [DATA_W-1:0] quo, qnext, mul_a;
  logic [3:0]        q10_lo, rem, digit;
  logic [CNT_W-1:0]  ndig_inc, body, len;
  logic              conv_done, sign_fit, emit_go;
  logic [CNT_W-1:0]  pos_ext;
  logic [7:0]        emit_char;

  assign quo    = DATA_W'(prod_r[PROD_W-1:RECIP_SHIFT]);
  assign q10_lo = {quo[0], 3'b000} + {quo[2:0], 1'b0};
  assign rem    = val_r[3:0] - q10_lo;
  assign digit  = hex_r ? val_r[3:0] : rem;
  assign qnext  = hex_r ? {4'b0000, val_r[DATA_W-1:4]} : quo;
  assign mul_a  = (state_r == ST_IDLE) ? head_req.mag : qnext;

  assign ndig_inc  = ndig_r + CNT_W'(1);
  assign conv_done = (qnext == '0) || (ndig_inc == CNT_W'(CAPACITY));
  assign sign_fit  = neg_r && (ndig_inc < CNT_W'(CAPACITY));
  assign body      = ndig_inc + CNT_W'(sign_fit);
  assign len       = (body > width_r) ? body : width_r;

  assign pos_ext = CNT_W'(pos_r);
  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign pop     = (state_r == ST_IDLE) && head_valid;

  always_comb begin
    if (pos_ext < ndig_r) begin
      emit_char = iaf_digit_char(dig_r[pos_r], lower_r);
    end else if (sign_r && pos_ext == ndig_r) begin
      emit_char = CH_MINUS;
    end else begin
      emit_char = zpad_r ? CH_ZERO : CH_SPACE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ndig_nxt  = ndig_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          state_nxt = ST_CONV;
          ndig_nxt  = '0;
        end
      end
      ST_CONV: begin
        ndig_nxt = ndig_inc;
        if (conv_done) begin
          state_nxt = ST_EMIT;
          pos_nxt   = IDX_W'(len - CNT_W'(1));
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r - IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ndig_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ndig_r      <= ndig_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= emit_go || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(RECIP_TEN);
    if (pop) begin
      val_r   <= head_req.mag;
      hex_r   <= head_req.hex;
      lower_r <= head_req.lower;
      neg_r   <= head_req.neg;
      zpad_r  <= head_req.zpad;
      width_r <= head_req.width;
    end
    if (state_r == ST_CONV) begin
      dig_r[ndig_r[IDX_W-1:0]] <= digit;
      val_r                    <= qnext;
      if (conv_done) begin
        sign_r <= sign_fit;
      end
    end
    if (emit_go) begin
      out_char_r <= emit_char;
      out_last_r <= (pos_r == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r == ST_CONV |-> ndig_r < CNT_W'(CAPACITY))
    else $error("digit count overran the buffer");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == ST_CONV && hex_r) |-> ndig_r < CNT_W'(HEX_DIGITS))
    else $error("too many hex digits");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (emit_go && pos_r == '0) |=> state_r == ST_IDLE && out_valid_r && out_last_r)
    else $error("final word not marked last");

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Converts a 32-bit value to a padded decimal or hex character field.
// ----------------------------------------------------------------------------
// Each input word is one conversion request: value, radix, hex case, signed
// mode, zero padding and a field width of up to 15 characters. The result
// channel carries one ASCII character per word, most significant first, and
// out_last_char marks the final character of a request.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. A two-entry request queue sits between the front end and the
// converter, so up to two requests are taken while a conversion runs.
// The converter loads a request, extracts one digit per cycle (one
// reciprocal multiply per decimal digit, up to 10, or up to 8 in hex)
// and then sends up to 15 characters, one per cycle while the receiver
// does not stall. It finishes a request before it takes the next one.
// When the receiver stalls, the output register holds its word and the
// converter waits; the queue keeps accepting until full.
// Reset empties the queue and the output register; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter import iaf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_hex_radix,
  input  logic              in_lower_case,
  input  logic              in_signed_mode,
  input  logic              in_zero_pad,
  input  logic [3:0]        in_field_width,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char_out,
  output logic              out_last_char
);

  iaf_req_t push_req, head_req;
  logic     q_full, q_push, q_pop, head_valid;

  iaf_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_hex_radix   (in_hex_radix),
    .in_lower_case  (in_lower_case),
    .in_signed_mode (in_signed_mode),
    .in_zero_pad    (in_zero_pad),
    .in_field_width (in_field_width),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_req          (push_req)
  );

  iaf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_req   (push_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  iaf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_req      (head_req),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_out  (out_char_out),
    .out_last_char (out_last_char)
  );

endmodule

// ===== tb/sv/format_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer formatter checker
// Watches both channels of the formatter, builds the expected characters of
// every accepted request and compares each result word with the oldest one.
// ----------------------------------------------------------------------------
module format_checker import iaf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [DATA_W-1:0] in_value,
  input  logic              in_hex_radix,
  input  logic              in_lower_case,
  input  logic              in_signed_mode,
  input  logic              in_zero_pad,
  input  logic [3:0]        in_field_width,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [7:0]        out_char_out,
  input  logic              out_last_char,
  output int                mismatch_count,
  output int                chars_owed
);

  typedef struct packed {
    logic [7:0] glyph;
    logic       last;
  } char_word_t;

  char_word_t expected_chars[$];
  int         error_tally = 0;

  function automatic void predict_conversion(input logic [DATA_W-1:0] value,
                                             input logic hex, input logic lower,
                                             input logic sgn, input logic zpad,
                                             input logic [3:0] width);
    logic [7:0]        field_buf [CAPACITY];
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] radix;
    logic [3:0]        digit;
    logic [7:0]        glyph;
    logic              neg;
    int                pos;
    int                stop;
    char_word_t        word;
    mag   = value;
    neg   = 1'b0;
    radix = hex ? 32'd16 : 32'd10;
    pos   = CAPACITY;
    if (!hex && sgn && value[DATA_W-1]) begin
      mag = 32'd0 - value;
      neg = 1'b1;
    end
    do begin
      digit = 4'(mag % radix);
      glyph = CH_ZERO + {4'b0000, digit};
      if (glyph > CH_NINE) begin
        glyph = glyph + (lower ? LOWER_ADJ : UPPER_ADJ);
      end
      pos--;
      field_buf[pos] = glyph;
      mag = mag / radix;
    end while (pos > 0 && mag != 0);
    if (pos > 0 && neg) begin
      pos--;
      field_buf[pos] = CH_MINUS;
    end
    stop = CAPACITY - int'(width);
    while (pos > 0 && pos > stop) begin
      pos--;
      field_buf[pos] = zpad ? CH_ZERO : CH_SPACE;
    end
    for (int k = pos; k < CAPACITY; k++) begin
      word.glyph = field_buf[k];
      word.last  = (k == CAPACITY - 1);
      expected_chars.push_back(word);
    end
  endfunction

  always @(posedge clk) begin
    char_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word: got char %h last %b", $time,
                   out_char_out, out_last_char);
          error_tally++;
        end else begin
          want = expected_chars.pop_front();
          if (out_char_out !== want.glyph) begin
            $display("%0t: char_out differs: expected %h, actual %h", $time,
                     want.glyph, out_char_out);
            error_tally++;
          end
          if (out_last_char !== want.last) begin
            $display("%0t: last_char differs: expected %b, actual %b", $time,
                     want.last, out_last_char);
            error_tally++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_conversion(in_value, in_hex_radix, in_lower_case, in_signed_mode,
                           in_zero_pad, in_field_width);
      end
    end
    mismatch_count <= error_tally;
    chars_owed     <= expected_chars.size();
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer formatter testbench
// Sends directed and random conversion requests with random idling on both
// channels and a long receiver hold-off, then reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top import iaf_pkg::*;;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid;
  logic              in_stall;
  logic [DATA_W-1:0] in_value;
  logic              in_hex_radix;
  logic              in_lower_case;
  logic              in_signed_mode;
  logic              in_zero_pad;
  logic [3:0]        in_field_width;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_char_out;
  logic              out_last_char;
  int                mismatch_count;
  int                chars_owed;

  bit calm         = 1'b0;
  bit hold_request = 1'b0;
  bit holding      = 1'b0;
  int gap_pct      = 25;
  int stall_pct    = 20;

  always #10 clk = ~clk;

  integer_to_ascii_formatter u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_hex_radix   (in_hex_radix),
    .in_lower_case  (in_lower_case),
    .in_signed_mode (in_signed_mode),
    .in_zero_pad    (in_zero_pad),
    .in_field_width (in_field_width),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_last_char  (out_last_char)
  );

  format_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_hex_radix   (in_hex_radix),
    .in_lower_case  (in_lower_case),
    .in_signed_mode (in_signed_mode),
    .in_zero_pad    (in_zero_pad),
    .in_field_width (in_field_width),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_last_char  (out_last_char),
    .mismatch_count (mismatch_count),
    .chars_owed     (chars_owed)
  );

  task automatic send_request(input logic [DATA_W-1:0] value, input logic hex,
                              input logic lower, input logic sgn, input logic zpad,
                              input logic [3:0] width);
    if (!calm && !holding && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_hex_radix   <= hex;
    in_lower_case  <= lower;
    in_signed_mode <= sgn;
    in_zero_pad    <= zpad;
    in_field_width <= width;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    logic [DATA_W-1:0] value;
    in_valid       <= 1'b0;
    in_value       <= '0;
    in_hex_radix   <= 1'b0;
    in_lower_case  <= 1'b0;
    in_signed_mode <= 1'b0;
    in_zero_pad    <= 1'b0;
    in_field_width <= 4'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(32'd0,          1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_request(32'd0,          1'b1, 1'b0, 1'b0, 1'b1, 4'd15);
    send_request(32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0, 4'd0);
    send_request(32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0, 1'b0, 4'd0);
    send_request(32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, 1'b0, 4'd15);
    send_request(32'h8000_0000,  1'b0, 1'b0, 1'b1, 1'b0, 4'd0);
    send_request(32'h8000_0000,  1'b0, 1'b0, 1'b1, 1'b1, 4'd15);
    send_request(32'hFFFF_FFFB,  1'b0, 1'b0, 1'b1, 1'b1, 4'd4);
    send_request(32'hFFFF_FFFB,  1'b0, 1'b0, 1'b1, 1'b0, 4'd4);
    send_request(32'hFFFF_FFFF,  1'b0, 1'b0, 1'b1, 1'b0, 4'd1);
    send_request(32'h8000_0000,  1'b1, 1'b0, 1'b1, 1'b0, 4'd0);
    send_request(32'hFFFF_FFFB,  1'b1, 1'b1, 1'b1, 1'b1, 4'd10);
    send_request(32'd1234567890, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0);
    send_request(32'h7FFF_FFFF,  1'b0, 1'b0, 1'b1, 1'b1, 4'd12);
    send_request(32'd123456,     1'b0, 1'b0, 1'b0, 1'b1, 4'd3);
    send_request(32'd42,         1'b0, 1'b0, 1'b0, 1'b0, 4'd15);
    send_request(32'hDEAD_BEEF,  1'b1, 1'b1, 1'b0, 1'b1, 4'd12);
    send_request(32'hABCD_EF01,  1'b1, 1'b0, 1'b0, 1'b0, 4'd9);
    send_request(32'd9,          1'b0, 1'b0, 1'b0, 1'b0, 4'd2);
    send_request(32'd10,         1'b0, 1'b0, 1'b1, 1'b0, 4'd2);
    send_request(32'h0000_000F,  1'b1, 1'b1, 1'b0, 1'b0, 4'd1);
    send_request(32'h0000_0010,  1'b1, 1'b0, 1'b0, 1'b1, 4'd8);
    send_request(32'd0,          1'b0, 1'b1, 1'b1, 1'b0, 4'd7);

    for (int i = 0; i < 148; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 25;
          default: gap_pct = 60;
        endcase
      end
      if (i == 50) begin
        hold_request = 1'b1;
      end
      if (i == 120) begin
        calm = 1'b1;
      end
      case ($urandom_range(0, 4))
        0: value = $urandom;
        1: value = $urandom_range(0, 999);
        2: value = 32'd0 - $urandom_range(1, 99999);
        3: value = ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)
                   ^ $urandom_range(0, 15);
        default: value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
      endcase
      send_request(value, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                   4'($urandom_range(0, 15)));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (chars_owed == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // The receiver side: short stall bursts, quiet stretches and one long hold-off
  // that lets the request queue fill and back up into the input channel.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        holding      = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        holding = 1'b0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
